// File: sv/kcf_pkg.sv
// kcf_pkg: shared constants, item type and crc byte update for the kiss command framer
// no dependencies; compile first
`default_nettype none

package kcf_pkg;

   localparam logic [7:0]  KissFend  = 8'hC0;
   localparam logic [7:0]  KissFesc  = 8'hDB;
   localparam logic [7:0]  KissTfend = 8'hDC;
   localparam logic [7:0]  KissTfesc = 8'hDD;
   localparam logic [7:0]  KissType  = 8'h00;
   localparam logic [15:0] CrcPoly   = 16'h1021;
   localparam logic [15:0] CrcInit   = 16'hFFFF;

   // one accepted command byte together with the crc after it
   typedef struct packed {
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [7:0]  count;
      logic [15:0] crc;
   } item_type;

   // crc-16 byte update, msb first, no reflection (pure xor network)
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: sv/kcf_ifs.sv
// kcf_req_if and kcf_rsp_if: valid/ready channels of the kiss command framer
// no dependencies
`default_nettype none

interface kcf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       last_byte;
   logic [7:0] payload_count;

   modport source (output valid, output data_byte, output first_byte,
                   output last_byte, output payload_count, input ready);
   modport sink   (input valid, input data_byte, input first_byte,
                   input last_byte, input payload_count, output ready);
endinterface

interface kcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// File: sv/kiss_command_framer_crc16_top.sv
// kiss_command_framer_crc16_top: kiss frame builder with crc-16 over length and payload
// depends on kcf_pkg, kcf_ifs, kcf_crc and kcf_emit
`default_nettype none

// takes one command payload byte per beat on req_chan and produces the kiss
// encoded frame one byte per beat on rsp_chan. a beat marked first_byte opens
// the frame with fend, type 0 and the escaped length byte; every payload byte
// is escaped (db -> db dd, c0 -> db dc); a beat marked last_byte closes it with
// the escaped crc-16 (poly 0x1021, init 0xffff, msb first, no final xor) over
// the length and payload, high byte first, then a fend flagged by frame_end.
// the crc is worked out in the accept cycle, so each byte's results leave one
// per cycle, while the output register is empty or rsp_chan is ready, from a
// single item slot into the output register: an item yields one frame byte
// for a plain payload byte, two for an escaped one, up to eleven for a
// single-byte command, and the next item is taken in the same cycle as the
// previous item's final byte is loaded into the output register. no clearing pass

module kiss_command_framer_crc16_top (
   input  logic      clock,
   input  logic      reset,
   kcf_req_if.sink   req_chan,
   kcf_rsp_if.source rsp_chan
);
   import kcf_pkg::*;

   logic        accept;
   logic        item_ready;
   logic [15:0] item_crc;
   item_type    item;

   // beat taken whenever the slot is empty or drains this cycle
   assign req_chan.ready = item_ready;
   assign accept         = req_chan.valid && item_ready;

   // running crc, restarted by a first byte and reset after a last byte
   kcf_crc u_crc (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_chan.data_byte),
      .first_byte    (req_chan.first_byte),
      .last_byte     (req_chan.last_byte),
      .payload_count (req_chan.payload_count),
      .item_crc      (item_crc)
   );

   // capture the beat together with the crc it leaves behind
   always_comb begin
      item.data  = req_chan.data_byte;
      item.first = req_chan.first_byte;
      item.last  = req_chan.last_byte;
      item.count = req_chan.payload_count;
      item.crc   = item_crc;
   end

   // sequencer and output register
   kcf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .item_load  (accept),
      .item       (item),
      .item_ready (item_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

// File: sv/kcf_crc.sv
// kcf_crc: running crc register, gives the crc after each accepted byte
// depends on kcf_pkg
`default_nettype none

module kcf_crc (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  data_byte,
   input  logic        first_byte,
   input  logic        last_byte,
   input  logic [7:0]  payload_count,
   output logic [15:0] item_crc
);
   import kcf_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] base;

   always_comb begin
      // a first byte restarts the crc over the length byte
      base     = first_byte ? crc_feed(CrcInit, payload_count) : crc_ff;
      item_crc = crc_feed(base, data_byte);
      crc_in   = crc_ff;
      if (accept) begin
         crc_in = last_byte ? CrcInit : item_crc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CrcInit;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/kcf_emit.sv
// kcf_emit: item slot, frame byte sequencer with escaping, and output register
// depends on kcf_pkg and kcf_rsp_if
`default_nettype none

module kcf_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_load,
   input  kcf_pkg::item_type  item,
   output logic               item_ready,
   kcf_rsp_if.source          rsp_chan
);
   import kcf_pkg::*;

   localparam logic [2:0] PhFend0 = 3'd0;
   localparam logic [2:0] PhType  = 3'd1;
   localparam logic [2:0] PhCount = 3'd2;
   localparam logic [2:0] PhData  = 3'd3;
   localparam logic [2:0] PhCrcHi = 3'd4;
   localparam logic [2:0] PhCrcLo = 3'd5;
   localparam logic [2:0] PhFend1 = 3'd6;

   logic       slot_valid_ff, slot_valid_in;
   item_type   slot_ff, slot_in;
   logic [2:0] phase_ff, phase_in;
   logic       esc_ff, esc_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_end_ff, out_end_in;

   logic       load_out;
   logic       step;
   logic [7:0] cur;
   logic       escapable;
   logic       is_end;
   logic       fin;
   logic [2:0] nxt;
   logic [7:0] emit_byte;
   logic       advance;
   logic       done;

   always_comb begin
      cur       = KissFend;
      escapable = 1'b0;
      is_end    = 1'b0;
      fin       = 1'b0;
      nxt       = phase_ff;
      unique case (phase_ff)
         PhFend0: begin
            cur = KissFend;
            nxt = PhType;
         end
         PhType: begin
            cur = KissType;
            nxt = PhCount;
         end
         PhCount: begin
            cur       = slot_ff.count;
            escapable = 1'b1;
            nxt       = PhData;
         end
         PhData: begin
            cur       = slot_ff.data;
            escapable = 1'b1;
            nxt       = PhCrcHi;
            fin       = !slot_ff.last;
         end
         PhCrcHi: begin
            cur       = slot_ff.crc[15:8];
            escapable = 1'b1;
            nxt       = PhCrcLo;
         end
         PhCrcLo: begin
            cur       = slot_ff.crc[7:0];
            escapable = 1'b1;
            nxt       = PhFend1;
         end
         PhFend1: begin
            cur    = KissFend;
            is_end = 1'b1;
            fin    = 1'b1;
         end
         default: begin
            cur = KissFend;
            fin = 1'b1;
         end
      endcase

      // second half of an escape pair, then escape lead-in, then plain byte
      priority if (esc_ff) begin
         emit_byte = (cur == KissFend) ? KissTfend : KissTfesc;
         advance   = 1'b1;
      end else if (escapable && (cur == KissFend || cur == KissFesc)) begin
         emit_byte = KissFesc;
         advance   = 1'b0;
      end else begin
         emit_byte = cur;
         advance   = 1'b1;
      end

      load_out   = !out_valid_ff || rsp_chan.ready;
      step       = slot_valid_ff && load_out;
      done       = advance && fin;
      item_ready = !slot_valid_ff || (step && done);

      slot_valid_in = slot_valid_ff;
      slot_in       = slot_ff;
      phase_in      = phase_ff;
      esc_in        = esc_ff;
      if (item_load) begin
         slot_valid_in = 1'b1;
         slot_in       = item;
         phase_in      = item.first ? PhFend0 : PhData;
         esc_in        = 1'b0;
      end else if (step && done) begin
         slot_valid_in = 1'b0;
         esc_in        = 1'b0;
      end else if (step) begin
         if (advance) begin
            phase_in = nxt;
            esc_in   = 1'b0;
         end else begin
            esc_in   = 1'b1;
         end
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_end_in   = is_end;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         phase_ff      <= PhFend0;
         esc_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         phase_ff      <= phase_in;
         esc_ff        <= esc_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.frame_byte = out_byte_ff;
   assign rsp_chan.frame_end  = out_end_ff;

endmodule

`default_nettype wire
